[rtl/scba_pkg.sv]
// Shared types and constants of the size-class block allocator.
package scba_pkg;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;
    localparam int INDEX_W  = 4;

    localparam int NUM_CLASSES = 3;

    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam class_t CLASS_8  = 2'd0;
    localparam class_t CLASS_16 = 2'd1;
    localparam class_t CLASS_32 = 2'd2;

    localparam status_t ST_ALLOCATED     = 3'd0;
    localparam status_t ST_FREED         = 3'd1;
    localparam status_t ST_TOO_LARGE     = 3'd2;
    localparam status_t ST_EMPTY         = 3'd3;
    localparam status_t ST_NOT_IN_POOL   = 3'd4;
    localparam status_t ST_NOT_ALLOCATED = 3'd5;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Largest request size of each class, in bytes.
    localparam logic [SIZE_W-1:0] SIZE_8  = 8'd8;
    localparam logic [SIZE_W-1:0] SIZE_16 = 8'd16;
    localparam logic [SIZE_W-1:0] SIZE_32 = 8'd32;

    // Decoded request, held in the input register.
    typedef struct packed {
        logic   kind;
        logic   too_large;
        logic   out_of_pool;
        class_t cls;
    } req_info_t;

    // State update issued when an item leaves the execute stage.
    typedef struct packed {
        logic   pop;
        logic   unmark;
        logic   push;
        class_t cls;
    } stack_op_t;

endpackage

[rtl/size_class_block_allocator.sv]
// Top level of the size-class block allocator: input stage, execute logic, result register.
//
// Allocates and frees fixed blocks of 8, 16 and 32 bytes from a pool that starts at
// pool_base and holds BLOCKS_PER_CLASS blocks of each class, smallest class first.
// Every request word produces exactly one result word. The block takes one word per cycle
// unless a full result register is unread: the request is decoded into the input register,
// and the execute logic writes the result register when the word advances. The throughput
// is set by the free-stack memory, which has one read port; the read of the next
// stack top is issued when a word is accepted, with the count already adjusted for
// the word in execution and a bypass from the push being written in the same cycle.
// No clearing pass is needed after reset: a low-water mark per class tells which
// stack entries still hold their reset contents. pool_base may only be written while
// no request word is in flight; the configuration channel is always ready.
module size_class_block_allocator #(
    parameter int BLOCKS_PER_CLASS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scba_pkg::ADDR_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [scba_pkg::SIZE_W-1:0]   request_size,
    input  logic [scba_pkg::ADDR_W-1:0]   block_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [scba_pkg::STATUS_W-1:0] status,
    output logic [scba_pkg::ADDR_W-1:0]   result_address,
    output logic [scba_pkg::CLASS_W-1:0]  size_class,
    output logic [scba_pkg::INDEX_W-1:0]  block_index
);
    import scba_pkg::*;

    localparam int IDX_W = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam int CNT_W = $clog2(BLOCKS_PER_CLASS + 1);
    localparam logic [ADDR_W-1:0] OFF_16 = ADDR_W'(8 * BLOCKS_PER_CLASS);
    localparam logic [ADDR_W-1:0] OFF_32 = ADDR_W'(24 * BLOCKS_PER_CLASS);

    logic [ADDR_W-1:0] pool_base_reg;

    // Decode of the incoming word.
    req_info_t         dec_info;
    logic [IDX_W-1:0]  dec_idx;

    // Input register.
    logic              stage_valid_reg;
    logic              stage_valid_next;
    req_info_t         stage_info_reg;
    logic [IDX_W-1:0]  stage_idx_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    logic [ADDR_W-1:0] addr_reg;
    class_t            class_reg;
    logic [INDEX_W-1:0] index_reg;

    logic              accept;
    logic              advance;

    // Free-stack interface.
    stack_op_t         stack_op;
    logic [IDX_W-1:0]  op_idx;
    logic [IDX_W-1:0]  top_idx;
    logic [NUM_CLASSES-1:0][CNT_W-1:0] cls_count;
    logic [NUM_CLASSES-1:0][BLOCKS_PER_CLASS-1:0] cls_in_use;

    // Execute results.
    status_t           exec_status;
    class_t            exec_cls;
    logic [IDX_W-1:0]  exec_idx;
    logic [ADDR_W-1:0] exec_addr;
    logic [ADDR_W-1:0] blk_ext;
    logic [CNT_W-1:0]  sel_count;
    logic              sel_in_use;
    logic              exec_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            pool_base_reg <= cfg_data;
        end
    end

    scba_decode #(
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    ) u_decode (
        .kind          (kind),
        .request_size  (request_size),
        .block_address (block_address),
        .pool_base     (pool_base_reg),
        .info          (dec_info),
        .free_idx      (dec_idx)
    );

    // The input register empties when its word moves into the result register, which
    // happens whenever the result register is empty or is being read this cycle.
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_info_reg <= dec_info;
            stage_idx_reg  <= dec_idx;
        end
        if (advance)
        begin
            status_reg <= exec_status;
            addr_reg   <= exec_addr;
            class_reg  <= exec_cls;
            index_reg  <= blk_ext[INDEX_W-1:0];
        end
    end

    // Execute: decide the outcome from the free count, the in-use bit and the stack
    // top that was read when the word was accepted. State changes only on advance.
    always_comb
    begin
        sel_count   = cls_count[stage_info_reg.cls];
        sel_in_use  = cls_in_use[stage_info_reg.cls][stage_idx_reg];
        exec_status = ST_ALLOCATED;
        exec_cls    = stage_info_reg.cls;
        exec_idx    = '0;
        exec_ok     = 1'b0;
        stack_op    = '0;
        stack_op.cls = stage_info_reg.cls;
        op_idx      = stage_idx_reg;

        if (stage_info_reg.kind == KIND_ALLOC)
        begin
            op_idx = top_idx;
            priority if (stage_info_reg.too_large)
            begin
                exec_status = ST_TOO_LARGE;
                exec_cls    = CLASS_8;
            end
            else if (sel_count == '0)
            begin
                exec_status = ST_EMPTY;
            end
            else
            begin
                exec_status  = ST_ALLOCATED;
                exec_idx     = top_idx;
                exec_ok      = 1'b1;
                stack_op.pop = advance;
            end
        end
        else
        begin
            priority if (stage_info_reg.out_of_pool)
            begin
                exec_status = ST_NOT_IN_POOL;
                exec_cls    = CLASS_8;
            end
            else if (!sel_in_use)
            begin
                exec_status = ST_NOT_ALLOCATED;
                exec_idx    = stage_idx_reg;
            end
            else
            begin
                exec_status      = ST_FREED;
                exec_idx         = stage_idx_reg;
                exec_ok          = 1'b1;
                stack_op.unmark  = advance;
                stack_op.push    = advance && (sel_count < CNT_W'(BLOCKS_PER_CLASS));
            end
        end

        blk_ext = ADDR_W'(exec_idx);
        unique case (exec_cls)
            CLASS_16: exec_addr = pool_base_reg + OFF_16 + (blk_ext << 4);
            CLASS_32: exec_addr = pool_base_reg + OFF_32 + (blk_ext << 5);
            default:  exec_addr = pool_base_reg + (blk_ext << 3);
        endcase
        if (!exec_ok)
        begin
            exec_addr = '0;
        end
    end

    scba_free_stack #(
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    ) u_free_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (stack_op),
        .op_idx  (op_idx),
        .rd_en   (accept),
        .rd_cls  (dec_info.cls),
        .top_idx (top_idx),
        .count   (cls_count),
        .in_use  (cls_in_use)
    );

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_address = addr_reg;
    assign size_class     = class_reg;
    assign block_index    = index_reg;

    // Every block of a class is either on its free stack or marked in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(cls_in_use[0]) + int'(cls_count[0]) == BLOCKS_PER_CLASS) &&
        ($countones(cls_in_use[1]) + int'(cls_count[1]) == BLOCKS_PER_CLASS) &&
        ($countones(cls_in_use[2]) + int'(cls_count[2]) == BLOCKS_PER_CLASS))
        else $error("free count and in-use bits disagree");

    // A block popped from a free stack must not already be handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        stack_op.pop |-> !cls_in_use[stack_op.cls][top_idx])
        else $error("allocated a block that is already in use");

    // The input side stalls only behind a full, unread result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without back-pressure");

    // A new result word appears only after a word left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance))
        else $error("result word without a source word");

endmodule

[rtl/scba_decode.sv]
// Request decoder: size to class, free address to class and block index.
module scba_decode #(
    parameter int BLOCKS_PER_CLASS = 16
) (
    input  logic                      kind,
    input  logic [scba_pkg::SIZE_W-1:0] request_size,
    input  logic [scba_pkg::ADDR_W-1:0] block_address,
    input  logic [scba_pkg::ADDR_W-1:0] pool_base,
    output scba_pkg::req_info_t       info,
    output logic [((BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1)-1:0] free_idx
);
    import scba_pkg::*;

    localparam int IDX_W = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam logic [ADDR_W-1:0] OFF_16     = ADDR_W'(8 * BLOCKS_PER_CLASS);
    localparam logic [ADDR_W-1:0] OFF_32     = ADDR_W'(24 * BLOCKS_PER_CLASS);
    localparam logic [ADDR_W-1:0] POOL_BYTES = ADDR_W'(56 * BLOCKS_PER_CLASS);

    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] rel;
    logic [ADDR_W-1:0] rel_idx;
    class_t            alloc_cls;
    class_t            free_cls;

    assign offset = block_address - pool_base;

    always_comb
    begin
        priority if (request_size > SIZE_16)
        begin
            alloc_cls = CLASS_32;
        end
        else if (request_size > SIZE_8)
        begin
            alloc_cls = CLASS_16;
        end
        else
        begin
            alloc_cls = CLASS_8;
        end

        priority if (offset >= OFF_32)
        begin
            free_cls = CLASS_32;
            rel      = offset - OFF_32;
            rel_idx  = rel >> 5;
        end
        else if (offset >= OFF_16)
        begin
            free_cls = CLASS_16;
            rel      = offset - OFF_16;
            rel_idx  = rel >> 4;
        end
        else
        begin
            free_cls = CLASS_8;
            rel      = offset;
            rel_idx  = rel >> 3;
        end

        info.kind        = kind;
        info.too_large   = (request_size > SIZE_32);
        info.out_of_pool = (offset >= POOL_BYTES);
        info.cls         = (kind == KIND_FREE) ? free_cls : alloc_cls;
        free_idx         = rel_idx[IDX_W-1:0];
    end

endmodule

[rtl/scba_free_stack.sv]
// Per-class free stacks in one memory, free counts and block-in-use bits.
module scba_free_stack #(
    parameter int BLOCKS_PER_CLASS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scba_pkg::stack_op_t op,
    input  logic [((BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1)-1:0] op_idx,
    input  logic                rd_en,
    input  scba_pkg::class_t    rd_cls,
    output logic [((BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1)-1:0] top_idx,
    output logic [scba_pkg::NUM_CLASSES-1:0][$clog2(BLOCKS_PER_CLASS+1)-1:0] count,
    output logic [scba_pkg::NUM_CLASSES-1:0][BLOCKS_PER_CLASS-1:0] in_use
);
    import scba_pkg::*;

    localparam int IDX_W     = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam int CNT_W     = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic [IDX_W-1:0] mem [0:MEM_DEPTH-1];

    logic [NUM_CLASSES-1:0][CNT_W-1:0] count_reg;
    logic [NUM_CLASSES-1:0][CNT_W-1:0] count_next;
    // Lowest fill level seen since reset; entries below it still hold reset contents.
    logic [NUM_CLASSES-1:0][CNT_W-1:0] low_mark_reg;
    logic [NUM_CLASSES-1:0][CNT_W-1:0] low_mark_next;
    logic [NUM_CLASSES-1:0][BLOCKS_PER_CLASS-1:0] in_use_reg;
    logic [NUM_CLASSES-1:0][BLOCKS_PER_CLASS-1:0] in_use_next;

    logic [IDX_W-1:0]  rd_data_reg;
    logic              rd_fresh_reg;
    logic [IDX_W-1:0]  rd_fresh_val_reg;

    logic [CNT_W-1:0]  rd_pos;
    logic [MEM_AW-1:0] rd_base;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_base;
    logic [MEM_AW-1:0] wr_addr;

    always_comb
    begin
        count_next    = count_reg;
        low_mark_next = low_mark_reg;
        in_use_next   = in_use_reg;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (op.pop && (op.cls == class_t'(c)))
            begin
                count_next[c]             = count_reg[c] - 1'b1;
                in_use_next[c][op_idx]    = 1'b1;
            end
            if (op.unmark && (op.cls == class_t'(c)))
            begin
                in_use_next[c][op_idx]    = 1'b0;
            end
            if (op.push && (op.cls == class_t'(c)))
            begin
                count_next[c]             = count_reg[c] + 1'b1;
            end
            if (count_next[c] < low_mark_reg[c])
            begin
                low_mark_next[c] = count_next[c];
            end
        end
    end

    always_comb
    begin
        unique case (rd_cls)
            CLASS_16: rd_base = MEM_AW'(BLOCKS_PER_CLASS);
            CLASS_32: rd_base = MEM_AW'(2 * BLOCKS_PER_CLASS);
            default:  rd_base = '0;
        endcase
        unique case (op.cls)
            CLASS_16: wr_base = MEM_AW'(BLOCKS_PER_CLASS);
            CLASS_32: wr_base = MEM_AW'(2 * BLOCKS_PER_CLASS);
            default:  wr_base = '0;
        endcase
        rd_pos  = count_next[rd_cls] - 1'b1;
        rd_addr = rd_base + MEM_AW'(rd_pos);
        wr_addr = wr_base + MEM_AW'(count_reg[op.cls]);
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[wr_addr] <= op_idx;
        end
        if (rd_en)
        begin
            if (op.push && (wr_addr == rd_addr))
            begin
                rd_data_reg <= op_idx;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
            rd_fresh_reg     <= (rd_pos < low_mark_next[rd_cls]);
            rd_fresh_val_reg <= IDX_W'(BLOCKS_PER_CLASS - 1) - rd_pos[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                count_reg[c]    <= CNT_W'(BLOCKS_PER_CLASS);
                low_mark_reg[c] <= CNT_W'(BLOCKS_PER_CLASS);
            end
            in_use_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            low_mark_reg <= low_mark_next;
            in_use_reg   <= in_use_next;
        end
    end

    assign top_idx = rd_fresh_reg ? rd_fresh_val_reg : rd_data_reg;
    assign count   = count_reg;
    assign in_use  = in_use_reg;

endmodule
